@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher check failed");

// Next-cycle implication, checked outside reset.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher sequence check failed");

`endif

@@ hw/rtl/ptd_pkg.sv @@
// Shared constants for the periodic task dispatcher.
package ptd_pkg;

    // Slot registers that exist in hardware
    localparam int HW_SLOTS       = 4;
    localparam int SLOT_COUNT_DEF = 4;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int MASK_W     = 4;
    localparam int QRY_W      = 2;
    localparam int DUE_W      = 3;
    localparam int REM_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes above the period registers
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd5;

    // Result codes
    localparam logic [DUE_W-1:0]        DUE_NONE  = 3'd4;
    localparam logic signed [REM_W-1:0] REM_NONE  = -17'sd1;

endpackage

@@ hw/rtl/ptd_if.sv @@
// Request, response and configuration channel interfaces.
interface ptd_req_if;
    logic                             valid;
    logic                             ready;
    logic [ptd_pkg::TIME_W-1:0]       tick_ms;
    logic [ptd_pkg::QRY_W-1:0]        query_task;

    modport source (output valid, tick_ms, query_task, input ready);
    modport sink   (input valid, tick_ms, query_task, output ready);
endinterface

interface ptd_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [ptd_pkg::DUE_W-1:0]        due_task;
    logic signed [ptd_pkg::REM_W-1:0] query_remaining;

    modport source (output valid, due_task, query_remaining, input ready);
    modport sink   (input valid, due_task, query_remaining, output ready);
endinterface

interface ptd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ptd_pkg::CFG_IDX_W-1:0]    index;
    logic [ptd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ptd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ptd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/periodic_task_dispatcher.sv @@
// Periodic task dispatcher: slot scan over a last-dispatch RAM.
//
//  Channel  Dir  Handshake     Payload
//  req      in   valid/ready   tick_ms[31:0], query_task[1:0]
//  rsp      out  valid/ready   due_task[2:0], query_remaining[16:0] signed
//  cfg      in   valid/ready   index[2:0], data[31:0]
//
// A new request is taken only in idle: one RAM read per slot during the scan,
// then a finish state that writes back the dispatched slot, if any.
// The single read port of the last-dispatch RAM sets the scan length.
// cfg is always ready; a start_time write clears the per-slot valid bits, so
// no clearing pass is needed after reset or reload.
// A response waiting on rsp does not block the next request; it only holds
// the finish cycle until the output register is free.
`include "assert_macros.svh"

module periodic_task_dispatcher #(
    parameter int SLOT_COUNT = ptd_pkg::SLOT_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ptd_req_if.sink      req,
    ptd_rsp_if.source    rsp,
    ptd_cfg_if.sink      cfg
);

    localparam int ACTIVE = (SLOT_COUNT < ptd_pkg::HW_SLOTS) ? SLOT_COUNT : ptd_pkg::HW_SLOTS;
    localparam int AW     = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
    localparam int TW     = ptd_pkg::TIME_W;
    localparam int PW     = ptd_pkg::PERIOD_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [AW-1:0] LAST_SLOT = AW'(ACTIVE - 1);
    localparam logic [ptd_pkg::DUE_W-1:0] DUE_LIMIT = ptd_pkg::DUE_W'(ACTIVE);

    // Configuration registers
    logic [PW-1:0]                period_reg [ptd_pkg::HW_SLOTS];
    logic [ptd_pkg::MASK_W-1:0]   enable_reg;
    logic [TW-1:0]                start_time_reg;
    logic [ACTIVE-1:0]            entry_valid_reg;

    // Sequencer
    logic [1:0]                   state_reg, state_next;
    logic [AW-1:0]                cnt_reg, cnt_next;
    logic                         found_reg;
    logic [AW-1:0]                due_idx_reg;
    logic [TW-1:0]                cur_time_reg;
    logic [ptd_pkg::QRY_W-1:0]    qry_reg;
    logic [TW-1:0]                qlast_reg;

    // Output register
    logic                             rsp_valid_reg;
    logic [ptd_pkg::DUE_W-1:0]        rsp_due_reg;
    logic signed [ptd_pkg::REM_W-1:0] rsp_rem_reg;

    // RAM ports
    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_raddr;
    logic [TW-1:0]                ram_rdata;

    logic                         req_fire, fin_fire;
    logic [ptd_pkg::QRY_W-1:0]    scan_slot;
    logic [TW-1:0]                scan_last, scan_elapsed;
    logic [PW-1:0]                scan_period;
    logic                         scan_hit;
    logic [PW-1:0]                q_period;
    logic [TW-1:0]                q_elapsed;
    logic signed [ptd_pkg::REM_W-1:0] q_remain;
    logic [ptd_pkg::DUE_W-1:0]    due_code;
    logic                         rsp_due_ok;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign fin_fire  = (state_reg == S_FIN) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.due_task        = rsp_due_reg;
    assign rsp.query_remaining = rsp_rem_reg;

    // Last-dispatch store
    ptd_ram #(
        .WIDTH (TW),
        .DEPTH (ACTIVE),
        .AW    (AW)
    ) u_last_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (due_idx_reg),
        .wdata (cur_time_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read slot 0 on accept, then the next slot each scan cycle
    assign ram_re    = req_fire || ((state_reg == S_SCAN) && (cnt_reg != LAST_SLOT));
    assign ram_raddr = (state_reg == S_SCAN) ? AW'(cnt_reg + 1'b1) : '0;
    assign ram_we    = fin_fire && found_reg;

    // Slot evaluation; a slot not written since reload reads as start_time
    assign scan_slot    = ptd_pkg::QRY_W'(cnt_reg);
    assign scan_last    = entry_valid_reg[cnt_reg] ? ram_rdata : start_time_reg;
    assign scan_period  = period_reg[scan_slot];
    assign scan_elapsed = cur_time_reg - scan_last;
    assign scan_hit     = enable_reg[scan_slot] && (scan_period != '0)
                          && (scan_elapsed >= {{(TW-PW){1'b0}}, scan_period});

    // Remaining time of the queried slot after this request's update
    assign q_period  = period_reg[qry_reg];
    assign q_elapsed = (found_reg && (ptd_pkg::QRY_W'(due_idx_reg) == qry_reg))
                       ? '0 : (cur_time_reg - qlast_reg);

    always_comb
    begin
        if (q_period == '0)
        begin
            q_remain = ptd_pkg::REM_NONE;
        end
        else if (q_elapsed >= {{(TW-PW){1'b0}}, q_period})
        begin
            q_remain = '0;
        end
        else
        begin
            q_remain = {1'b0, q_period - q_elapsed[PW-1:0]};
        end
    end

    assign due_code = found_reg ? ptd_pkg::DUE_W'(due_idx_reg) : ptd_pkg::DUE_NONE;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = AW'(cnt_reg + 1'b1);
                end
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (req_fire)
            begin
                found_reg <= 1'b0;
            end
            else if ((state_reg == S_SCAN) && scan_hit)
            begin
                found_reg <= 1'b1;
            end
            if (fin_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers and per-slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ptd_pkg::HW_SLOTS; i++)
            begin
                period_reg[i] <= '0;
            end
            enable_reg      <= '0;
            start_time_reg  <= '0;
            entry_valid_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == ptd_pkg::REG_ENABLE)
                begin
                    enable_reg <= cfg.data[ptd_pkg::MASK_W-1:0];
                end
                else if (cfg.index == ptd_pkg::REG_START)
                begin
                    start_time_reg  <= cfg.data[TW-1:0];
                    entry_valid_reg <= '0;
                end
                else if (cfg.index < ptd_pkg::CFG_IDX_W'(ACTIVE))
                begin
                    period_reg[cfg.index[ptd_pkg::QRY_W-1:0]] <= cfg.data[PW-1:0];
                end
            end
            if (ram_we)
            begin
                entry_valid_reg[due_idx_reg] <= 1'b1;
            end
        end
    end

    // Request payload, scan captures and response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cur_time_reg <= req.tick_ms;
            qry_reg      <= req.query_task;
        end
        if (state_reg == S_SCAN)
        begin
            if (scan_hit && !found_reg)
            begin
                due_idx_reg <= cnt_reg;
            end
            if (scan_slot == qry_reg)
            begin
                qlast_reg <= scan_last;
            end
        end
        if (fin_fire)
        begin
            rsp_due_reg <= due_code;
            rsp_rem_reg <= q_remain;
        end
    end

    // Checks
    assign rsp_due_ok = (rsp.due_task < DUE_LIMIT) || (rsp.due_task == ptd_pkg::DUE_NONE);

    `PTD_ASSERT_NEXT(a_accept_scan, clk, rst_n, req_fire, state_reg == S_SCAN && cnt_reg == '0)
    `PTD_ASSERT_NOW(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE, !req.ready)
    `PTD_ASSERT_NOW(a_due_in_range, clk, rst_n, rsp.valid, rsp_due_ok)
    `PTD_ASSERT_NOW(a_write_fin, clk, rst_n, ram_we, state_reg == S_FIN && due_idx_reg <= LAST_SLOT)

endmodule
